// File: hw/rtl/ordered_list_position_edit_top_macros.svh
// Assertion macros shared by the checker of the ordered list block.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef ORDERED_LIST_POSITION_EDIT_TOP_MACROS_SVH
`define ORDERED_LIST_POSITION_EDIT_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define OLPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold at the next edge.
`define OLPE_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/olpe_pkg.sv
// ----------------------------------------------------------------------------
// olpe_pkg
// Command codes, status codes and decode types of the ordered list block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olpe_pkg;

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_BACK  = 3'd1;
	localparam logic [2:0] CMD_INS_POS   = 3'd2;
	localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [2:0] CMD_DEL_POS   = 3'd5;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_POS_LOW = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] status;
	} edit_t;

endpackage

// File: hw/rtl/ordered_list_position_edit_top.sv
// ----------------------------------------------------------------------------
// ordered_list_position_edit_top
// An accepted item is registered in stage s1, then in the output register.
// Throughput: one item per cycle while in_stall is low; the row of cells
// shifts or holds on accept; the result stage reads it as the item leaves s1.
// Reset clears the entry count and the valid flags; the cells need no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_position_edit_top #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     cmd,
	input  logic signed [31:0]             value,
	input  logic [4:0]                     position,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic [$clog2(DEPTH+1)-1:0]     count,
	output logic signed [31:0]             first_value,
	output logic signed [31:0]             last_value
);
	import olpe_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                 accept;
	logic                 s1_move;
	edit_t                edit;
	logic [IDX_W-1:0]     idx;
	logic [CNT_W-1:0]     entry_count_q;
	logic                 valid_s1;
	logic [2:0]           status_s1;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [CNT_W-1:0]     res_count_q;
	logic signed [31:0]   first_q;
	logic signed [31:0]   last_q;
	logic [IDX_W-1:0]     rd_idx;
	logic signed [31:0]   cell_data [DEPTH];

	assign s1_move  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;
	assign rd_idx   = IDX_W'(entry_count_q - CNT_W'(1));

	olpe_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.cmd         (cmd),
		.position    (position),
		.entry_count (entry_count_q),
		.edit        (edit),
		.idx         (idx)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_data;
		logic signed [31:0] right_data;

		if (i == 0) begin : g_first
			assign left_data = value;
		end else begin : g_mid_l
			assign left_data = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_data = cell_data[i];
		end else begin : g_mid_r
			assign right_data = cell_data[i+1];
		end

		olpe_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
			.clk        (clk),
			.en         (accept),
			.op         (edit.op),
			.idx        (idx),
			.value      (value),
			.left_data  (left_data),
			.right_data (right_data),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				unique case (edit.op)
					OP_INS: entry_count_q <= entry_count_q + CNT_W'(1);
					OP_DEL: entry_count_q <= entry_count_q - CNT_W'(1);
					default: begin
					end
				endcase
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= edit.status;
		end
		if (s1_move && valid_s1) begin
			status_q    <= status_s1;
			res_count_q <= entry_count_q;
			if (entry_count_q == '0) begin
				first_q <= '0;
				last_q  <= '0;
			end else begin
				first_q <= cell_data[0];
				last_q  <= cell_data[rd_idx];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign count       = res_count_q;
	assign first_value = first_q;
	assign last_value  = last_q;

endmodule

// File: hw/rtl/olpe_cell.sv
// ----------------------------------------------------------------------------
// olpe_cell
// One slot of the list: holds, loads the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olpe_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  logic                         en,
	input  olpe_pkg::op_t                op,
	input  logic [$clog2(DEPTH)-1:0]     idx,
	input  logic signed [31:0]           value,
	input  logic signed [31:0]           left_data,
	input  logic signed [31:0]           right_data,
	output logic signed [31:0]           data
);
	import olpe_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic signed [31:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (op)
				OP_INS: begin
					if (MY_IDX > idx) begin
						data_q <= left_data;
					end else if (MY_IDX == idx) begin
						data_q <= value;
					end
				end
				OP_DEL: begin
					if (MY_IDX >= idx) begin
						data_q <= right_data;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign data = data_q;

endmodule

// File: hw/rtl/olpe_ctrl.sv
// ----------------------------------------------------------------------------
// olpe_ctrl
// Checks a command against the entry count and picks the edit and its slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olpe_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic [2:0]                     cmd,
	input  logic [4:0]                     position,
	input  logic [$clog2(DEPTH+1)-1:0]     entry_count,
	output olpe_pkg::edit_t                edit,
	output logic [$clog2(DEPTH)-1:0]       idx
);
	import olpe_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W + 1 : 6;

	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] cnt_ext;
	logic             full;
	logic             empty;

	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(entry_count);
	assign full    = (cnt_ext == CMP_W'(DEPTH));
	assign empty   = (cnt_ext == '0);

	always_comb begin
		edit.op     = OP_NONE;
		edit.status = ST_OK;
		idx         = '0;
		unique case (cmd)
			CMD_INS_FRONT: begin
				if (full) begin
					edit.status = ST_FULL;
				end else begin
					edit.op = OP_INS;
				end
			end
			CMD_INS_BACK: begin
				if (full) begin
					edit.status = ST_FULL;
				end else begin
					edit.op = OP_INS;
					idx     = IDX_W'(cnt_ext);
				end
			end
			CMD_INS_POS: begin
				priority if (pos_ext == '0) begin
					edit.status = ST_POS_LOW;
				end else if (pos_ext > cnt_ext + CMP_W'(1)) begin
					edit.status = ST_RANGE;
				end else if (full) begin
					edit.status = ST_FULL;
				end else begin
					edit.op = OP_INS;
					idx     = IDX_W'(pos_ext - CMP_W'(1));
				end
			end
			CMD_DEL_FRONT: begin
				if (empty) begin
					edit.status = ST_EMPTY;
				end else begin
					edit.op = OP_DEL;
				end
			end
			CMD_DEL_BACK: begin
				if (empty) begin
					edit.status = ST_EMPTY;
				end else begin
					edit.op = OP_DEL;
					idx     = IDX_W'(cnt_ext - CMP_W'(1));
				end
			end
			CMD_DEL_POS: begin
				priority if (pos_ext == '0) begin
					edit.status = ST_POS_LOW;
				end else if (empty) begin
					edit.status = ST_EMPTY;
				end else if (pos_ext > cnt_ext) begin
					edit.status = ST_RANGE;
				end else begin
					edit.op = OP_DEL;
					idx     = IDX_W'(pos_ext - CMP_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/olpe_checker.sv
// ----------------------------------------------------------------------------
// olpe_checker
// Port-level checks of the ordered list block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ordered_list_position_edit_top_macros.svh"

module olpe_checker #(
	parameter int DEPTH = 16
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     status,
	input logic [$clog2(DEPTH+1)-1:0]     count,
	input logic signed [31:0]             first_value,
	input logic signed [31:0]             last_value
);
	import olpe_pkg::*;

	`OLPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(status) && $stable(count) && $stable(first_value)
		&& $stable(last_value), "Stalled result item changed.")
	`OLPE_ASSERT(a_empty_zero,
		!(out_valid && count == '0) || (first_value == '0 && last_value == '0),
		"Empty list reports nonzero entries.")
	`OLPE_ASSERT(a_count_max, !out_valid || count <= DEPTH, "Count exceeds depth.")
	`OLPE_ASSERT(a_full_count, !(out_valid && status == ST_FULL) || count == DEPTH,
		"Full status without a full list.")
	`OLPE_ASSERT(a_empty_count, !(out_valid && status == ST_EMPTY) || count == '0,
		"Empty status with entries present.")

endmodule

bind ordered_list_position_edit_top olpe_checker #(.DEPTH(DEPTH)) u_olpe_checker (.*);
